// File: sv/m2d_pkg.sv
// ----------------------------------------------------------------------------
// m2d_pkg
// shared widths, constants and stage bundles of the mrp to dcm core
// ----------------------------------------------------------------------------
package m2d_pkg;

   localparam int IN_W     = 32;            // mrp component, signed q3.28
   localparam int OUT_W    = 32;            // matrix entry, signed q1.30
   localparam int FRAC     = 28;            // fraction bits of the datapath
   localparam int OUT_FRAC = 30;            // fraction bits of an entry
   localparam int ENTRIES  = 9;             // matrix entries, row major

   localparam int SQ_W     = 36;            // m_i * m_j >>> 28
   localparam int S_W      = 36;            // sum of squares, unsigned
   localparam int SIG_W    = 37;            // 1 - s, signed
   localparam int SPLIT    = 18;            // low half of a split multiplier operand
   localparam int T_W      = 40;            // m_k * sig >>> 28
   localparam int DEN_W    = 45;            // (1 + s)^2, also holds sig^2
   localparam int NUM_W    = 48;            // numerator, signed
   localparam int MAG_W    = DEN_W + 2;     // numerator magnitude
   localparam int MAGQ_W   = OUT_FRAC + 1;  // entry magnitude, 0 .. 2^30
   localparam int QUO_W    = MAGQ_W + 1;    // quotient with one extra bit for rounding

   localparam logic [SIG_W-1:0]  ONE_SIG = {{(SIG_W-FRAC-1){1'b0}}, 1'b1, {FRAC{1'b0}}};
   localparam logic [MAGQ_W-1:0] ONE_MAG = {1'b1, {(MAGQ_W-1){1'b0}}};

   // numerators and divisor leaving the front end
   typedef struct packed {
      logic                             valid;
      logic [DEN_W-1:0]                 den;
      logic [ENTRIES-1:0][NUM_W-1:0]    num;
   } num_bus_type;

   // one lane of the long division
   typedef struct packed {
      logic              neg;
      logic              ovf;
      logic [QUO_W-1:0]  quo;
      logic [DEN_W-1:0]  rem;
   } lane_type;

   typedef struct packed {
      logic                        valid;
      logic [DEN_W-1:0]            den;
      lane_type [ENTRIES-1:0]      lane;
   } div_bus_type;

   // rounded and clipped magnitudes leaving the divider
   typedef struct packed {
      logic                            valid;
      logic [ENTRIES-1:0]              neg;
      logic [ENTRIES-1:0]              sat;
      logic [ENTRIES-1:0][MAGQ_W-1:0]  mag;
   } res_bus_type;

endpackage

// File: sv/mrp_to_direction_cosine_matrix_core.sv
// ----------------------------------------------------------------------------
// mrp_to_direction_cosine_matrix_core
// modified rodrigues parameters to 3x3 direction cosine matrix
// ----------------------------------------------------------------------------
// One attitude (three signed q3.28 parameters) enters per transfer and one
// row-major 3x3 matrix of signed q1.30 entries leaves per transfer, each
// entry rounded to nearest (ties away from zero) and clipped to +/-1.0, with
// saturated set when any entry was clipped. The core keeps no state between
// items and takes a new attitude every cycle unless req_stall is high. An
// input transfer passes five front-end stages for the squares, sums, split
// wide products and numerators, then the divider with one stage for sign and
// magnitude, 32 one-bit restoring division stages and one rounding stage,
// then the output register. The divider's bit-per-stage division sets the
// pipeline depth. A stalled result sits in the output register while the
// pipeline keeps filling; the input stalls only once the last pipeline stage
// also holds an item.
module mrp_to_direction_cosine_matrix_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [m2d_pkg::IN_W-1:0]    req_mrp_x,
   input  logic signed [m2d_pkg::IN_W-1:0]    req_mrp_y,
   input  logic signed [m2d_pkg::IN_W-1:0]    req_mrp_z,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [m2d_pkg::OUT_W-1:0]   rsp_r0_c0,
   output logic signed [m2d_pkg::OUT_W-1:0]   rsp_r0_c1,
   output logic signed [m2d_pkg::OUT_W-1:0]   rsp_r0_c2,
   output logic signed [m2d_pkg::OUT_W-1:0]   rsp_r1_c0,
   output logic signed [m2d_pkg::OUT_W-1:0]   rsp_r1_c1,
   output logic signed [m2d_pkg::OUT_W-1:0]   rsp_r1_c2,
   output logic signed [m2d_pkg::OUT_W-1:0]   rsp_r2_c0,
   output logic signed [m2d_pkg::OUT_W-1:0]   rsp_r2_c1,
   output logic signed [m2d_pkg::OUT_W-1:0]   rsp_r2_c2,
   output logic                               rsp_saturated
);
   import m2d_pkg::*;

   num_bus_type               front_bus;
   res_bus_type               tail;

   // output register
   logic                      rsp_valid_in, rsp_valid_ff;
   logic [OUT_W-1:0]          entry_in [ENTRIES], entry_ff [ENTRIES];
   logic                      sat_in, sat_ff;

   // pipeline advance
   logic                      out_hold;
   logic                      en;

   // a held result only blocks the pipeline when the tail has an item to hand over
   assign out_hold  = rsp_valid_ff && rsp_stall;
   assign en        = !(tail.valid && out_hold);
   assign req_stall = !en;

   m2d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .mrp_x     (req_mrp_x),
      .mrp_y     (req_mrp_y),
      .mrp_z     (req_mrp_z),
      .front_out (front_bus)
   );

   m2d_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .div_in  (front_bus),
      .div_out (tail)
   );

   // sign is applied on the way into the output register
   always_comb begin
      rsp_valid_in = out_hold ? 1'b1 : tail.valid;
      sat_in       = |tail.sat;
      for (int i = 0; i < ENTRIES; i++) begin
         entry_in[i] = tail.neg[i] ? (OUT_W'(0) - {1'b0, tail.mag[i]})
                                   : {1'b0, tail.mag[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_hold) begin
         entry_ff <= entry_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_r0_c0     = $signed(entry_ff[0]);
   assign rsp_r0_c1     = $signed(entry_ff[1]);
   assign rsp_r0_c2     = $signed(entry_ff[2]);
   assign rsp_r1_c0     = $signed(entry_ff[3]);
   assign rsp_r1_c1     = $signed(entry_ff[4]);
   assign rsp_r1_c2     = $signed(entry_ff[5]);
   assign rsp_r2_c0     = $signed(entry_ff[6]);
   assign rsp_r2_c1     = $signed(entry_ff[7]);
   assign rsp_r2_c2     = $signed(entry_ff[8]);
   assign rsp_saturated = sat_ff;

endmodule

// File: sv/m2d_front.sv
// ----------------------------------------------------------------------------
// m2d_front
// five stage front end: products, sums, split wide products, numerators
// ----------------------------------------------------------------------------
module m2d_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  logic                              in_valid,
   input  logic signed [m2d_pkg::IN_W-1:0]   mrp_x,
   input  logic signed [m2d_pkg::IN_W-1:0]   mrp_y,
   input  logic signed [m2d_pkg::IN_W-1:0]   mrp_z,
   output m2d_pkg::num_bus_type              front_out
);
   import m2d_pkg::*;

   localparam int PW     = 2 * IN_W;
   localparam int HALF_W = SIG_W - SPLIT;
   localparam int PP_W   = SIG_W + HALF_W;
   localparam int FULL_W = 2 * SIG_W;
   localparam int NPP    = 5;
   localparam int PP_SIG2 = 0;
   localparam int PP_DEN  = 1;
   localparam int PP_T0   = 2;

   // stage a: squares and cross products
   logic                      valid_a_in, valid_a_ff;
   logic signed [IN_W-1:0]    m_a_in [3], m_a_ff [3];
   logic signed [SQ_W-1:0]    sq_a_in [3], sq_a_ff [3];
   logic signed [SQ_W-1:0]    p_a_in [3], p_a_ff [3];
   logic signed [PW-1:0]      prod_a [6];

   // stage b: s, sig and 1 + s
   logic                      valid_b_in, valid_b_ff;
   logic signed [IN_W-1:0]    m_b_ff [3];
   logic signed [SQ_W-1:0]    sq_b_ff [3], p_b_ff [3];
   logic signed [SIG_W-1:0]   sig_b_in, sig_b_ff;
   logic [S_W-1:0]            spl_b_in, spl_b_ff;
   logic [S_W-1:0]            s_sum;

   // stage c: half products of the wide multiplications
   logic                      valid_c_in, valid_c_ff;
   logic signed [SQ_W-1:0]    sq_c_ff [3], p_c_ff [3];
   logic signed [PP_W-1:0]    hi_c_in [NPP], hi_c_ff [NPP];
   logic signed [PP_W-1:0]    lo_c_in [NPP], lo_c_ff [NPP];
   logic signed [SIG_W-1:0]   opa [NPP], src [NPP];
   logic signed [HALF_W-1:0]  half_hi [NPP], half_lo [NPP];

   // stage d: joined products
   logic                      valid_d_in, valid_d_ff;
   logic signed [SQ_W-1:0]    sq_d_ff [3], p_d_ff [3];
   logic [DEN_W-1:0]          sig2_d_in, sig2_d_ff;
   logic [DEN_W-1:0]          den_d_in, den_d_ff;
   logic signed [T_W-1:0]     t_d_in [3], t_d_ff [3];
   logic signed [FULL_W-1:0]  full [NPP];

   // stage e: numerators
   logic                      valid_e_in, valid_e_ff;
   logic [DEN_W-1:0]          den_e_ff;
   logic signed [NUM_W-1:0]   num_e_in [ENTRIES], num_e_ff [ENTRIES];
   logic signed [NUM_W-1:0]   e_sq [3], e_p [3], e_t [3], e_sig2;

   always_comb begin
      valid_a_in = in_valid;
      m_a_in[0]  = mrp_x;
      m_a_in[1]  = mrp_y;
      m_a_in[2]  = mrp_z;
      prod_a[0]  = PW'(mrp_x) * PW'(mrp_x);
      prod_a[1]  = PW'(mrp_y) * PW'(mrp_y);
      prod_a[2]  = PW'(mrp_z) * PW'(mrp_z);
      prod_a[3]  = PW'(mrp_x) * PW'(mrp_y);
      prod_a[4]  = PW'(mrp_x) * PW'(mrp_z);
      prod_a[5]  = PW'(mrp_y) * PW'(mrp_z);
      for (int i = 0; i < 3; i++) begin
         sq_a_in[i] = prod_a[i][FRAC +: SQ_W];
         p_a_in[i]  = prod_a[i+3][FRAC +: SQ_W];
      end
   end

   always_comb begin
      valid_b_in = valid_a_ff;
      s_sum = S_W'($unsigned(sq_a_ff[0])) + S_W'($unsigned(sq_a_ff[1]))
            + S_W'($unsigned(sq_a_ff[2]));
      sig_b_in = $signed(ONE_SIG) - $signed({1'b0, s_sum});
      spl_b_in = ONE_SIG[S_W-1:0] + s_sum;
   end

   // each wide product a * b is split as a * b_hi * 2^SPLIT + a * b_lo
   always_comb begin
      valid_c_in = valid_b_ff;
      opa[PP_SIG2] = sig_b_ff;
      opa[PP_DEN]  = $signed({1'b0, spl_b_ff});
      for (int j = 0; j < 3; j++) begin
         opa[PP_T0+j] = SIG_W'(m_b_ff[j]);
      end
      for (int k = 0; k < NPP; k++) begin
         src[k]     = (k == PP_DEN) ? $signed({1'b0, spl_b_ff}) : sig_b_ff;
         half_hi[k] = src[k][SIG_W-1:SPLIT];
         half_lo[k] = $signed({1'b0, src[k][SPLIT-1:0]});
         hi_c_in[k] = PP_W'(opa[k]) * PP_W'(half_hi[k]);
         lo_c_in[k] = PP_W'(opa[k]) * PP_W'(half_lo[k]);
      end
   end

   always_comb begin
      valid_d_in = valid_c_ff;
      for (int k = 0; k < NPP; k++) begin
         full[k] = (FULL_W'(hi_c_ff[k]) <<< SPLIT) + FULL_W'(lo_c_ff[k]);
      end
      sig2_d_in = full[PP_SIG2][FRAC +: DEN_W];
      den_d_in  = full[PP_DEN][FRAC +: DEN_W];
      for (int j = 0; j < 3; j++) begin
         t_d_in[j] = full[PP_T0+j][FRAC +: T_W];
      end
   end

   always_comb begin
      valid_e_in = valid_d_ff;
      for (int j = 0; j < 3; j++) begin
         e_sq[j] = NUM_W'(sq_d_ff[j]);
         e_p[j]  = NUM_W'(p_d_ff[j]);
         e_t[j]  = NUM_W'(t_d_ff[j]);
      end
      e_sig2 = $signed({{(NUM_W-DEN_W){1'b0}}, sig2_d_ff});
      // p: 0 = xy, 1 = xz, 2 = yz
      num_e_in[0] = ((e_sq[0] - e_sq[1] - e_sq[2]) <<< 2) + e_sig2;
      num_e_in[1] = (e_p[0] <<< 3) + (e_t[2] <<< 2);
      num_e_in[2] = (e_p[1] <<< 3) - (e_t[1] <<< 2);
      num_e_in[3] = (e_p[0] <<< 3) - (e_t[2] <<< 2);
      num_e_in[4] = ((e_sq[1] - e_sq[0] - e_sq[2]) <<< 2) + e_sig2;
      num_e_in[5] = (e_p[2] <<< 3) + (e_t[0] <<< 2);
      num_e_in[6] = (e_p[1] <<< 3) + (e_t[1] <<< 2);
      num_e_in[7] = (e_p[2] <<< 3) - (e_t[0] <<< 2);
      num_e_in[8] = ((e_sq[2] - e_sq[0] - e_sq[1]) <<< 2) + e_sig2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
         valid_d_ff <= 1'b0;
         valid_e_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         valid_c_ff <= valid_c_in;
         valid_d_ff <= valid_d_in;
         valid_e_ff <= valid_e_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_a_ff   <= m_a_in;
         sq_a_ff  <= sq_a_in;
         p_a_ff   <= p_a_in;
         m_b_ff   <= m_a_ff;
         sq_b_ff  <= sq_a_ff;
         p_b_ff   <= p_a_ff;
         sig_b_ff <= sig_b_in;
         spl_b_ff <= spl_b_in;
         sq_c_ff  <= sq_b_ff;
         p_c_ff   <= p_b_ff;
         hi_c_ff  <= hi_c_in;
         lo_c_ff  <= lo_c_in;
         sq_d_ff  <= sq_c_ff;
         p_d_ff   <= p_c_ff;
         sig2_d_ff <= sig2_d_in;
         den_d_ff <= den_d_in;
         t_d_ff   <= t_d_in;
         den_e_ff <= den_d_ff;
         num_e_ff <= num_e_in;
      end
   end

   always_comb begin
      front_out.valid = valid_e_ff;
      front_out.den   = den_e_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         front_out.num[i] = num_e_ff[i];
      end
   end

endmodule

// File: sv/m2d_div_step.sv
// ----------------------------------------------------------------------------
// m2d_div_step
// one registered restoring division step for all nine lanes
// ----------------------------------------------------------------------------
module m2d_div_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  m2d_pkg::div_bus_type  prev_stage,
   output m2d_pkg::div_bus_type  next_stage
);
   import m2d_pkg::*;

   div_bus_type         stage_in, stage_ff;
   logic [DEN_W:0]      rem2 [ENTRIES];
   logic [DEN_W+1:0]    diff [ENTRIES];
   logic                qbit [ENTRIES];

   always_comb begin
      stage_in = prev_stage;
      for (int i = 0; i < ENTRIES; i++) begin
         rem2[i] = {prev_stage.lane[i].rem, 1'b0};
         diff[i] = {1'b0, rem2[i]} - {2'b00, prev_stage.den};
         qbit[i] = ~diff[i][DEN_W+1];
         stage_in.lane[i].rem = qbit[i] ? diff[i][DEN_W-1:0] : rem2[i][DEN_W-1:0];
         stage_in.lane[i].quo = {prev_stage.lane[i].quo[QUO_W-2:0], qbit[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign next_stage = stage_ff;

endmodule

// File: sv/m2d_divider.sv
// ----------------------------------------------------------------------------
// m2d_divider
// pipelined long division of nine numerators by one divisor, with rounding
// ----------------------------------------------------------------------------
module m2d_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  m2d_pkg::num_bus_type  div_in,
   output m2d_pkg::res_bus_type  div_out
);
   import m2d_pkg::*;

   // stage f: sign and magnitude
   logic                 valid_f_in, valid_f_ff;
   logic [DEN_W-1:0]     den_f_ff;
   logic [MAG_W-1:0]     mag_f_in [ENTRIES], mag_f_ff [ENTRIES];
   logic [ENTRIES-1:0]   neg_f_in, neg_f_ff;
   logic signed [NUM_W-1:0] num_s [ENTRIES];
   logic [NUM_W-1:0]     abs_v [ENTRIES];

   // stage g: range check and leading quotient bit
   div_bus_type          g_in, g_ff;
   logic [DEN_W:0]       r0 [ENTRIES];
   logic [DEN_W+1:0]     diff0 [ENTRIES];
   logic                 ovf [ENTRIES];
   logic                 qbit0 [ENTRIES];

   div_bus_type          step_bus [QUO_W];

   // stage r: round and clip
   res_bus_type          res_in, res_ff;
   lane_type             tail_lane [ENTRIES];
   logic [QUO_W:0]       rnd [ENTRIES];
   logic [QUO_W-1:0]     rounded [ENTRIES];
   logic                 clip [ENTRIES];

   always_comb begin
      valid_f_in = div_in.valid;
      for (int i = 0; i < ENTRIES; i++) begin
         num_s[i]    = $signed(div_in.num[i]);
         neg_f_in[i] = num_s[i][NUM_W-1];
         abs_v[i]    = neg_f_in[i] ? NUM_W'(-num_s[i]) : NUM_W'(num_s[i]);
         mag_f_in[i] = abs_v[i][MAG_W-1:0];
      end
   end

   // quotient holds floor(mag * 2^31 / den); mag >= 2 * den always clips
   always_comb begin
      g_in.valid = valid_f_ff;
      g_in.den   = den_f_ff;
      for (int i = 0; i < ENTRIES; i++) begin
         ovf[i]   = mag_f_ff[i] >= {1'b0, den_f_ff, 1'b0};
         r0[i]    = mag_f_ff[i][DEN_W:0];
         diff0[i] = {1'b0, r0[i]} - {2'b00, den_f_ff};
         qbit0[i] = ~diff0[i][DEN_W+1];
         g_in.lane[i].neg = neg_f_ff[i];
         g_in.lane[i].ovf = ovf[i];
         g_in.lane[i].quo = QUO_W'(qbit0[i]);
         if (ovf[i]) begin
            g_in.lane[i].rem = '0;
         end else if (qbit0[i]) begin
            g_in.lane[i].rem = diff0[i][DEN_W-1:0];
         end else begin
            g_in.lane[i].rem = r0[i][DEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_f_ff <= 1'b0;
      end else if (en) begin
         valid_f_ff <= valid_f_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         den_f_ff <= div_in.den;
         mag_f_ff <= mag_f_in;
         neg_f_ff <= neg_f_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff.valid <= 1'b0;
      end else if (en) begin
         g_ff <= g_in;
      end
   end

   assign step_bus[0] = g_ff;

   for (genvar j = 0; j < QUO_W - 1; j++) begin : g_step
      m2d_div_step u_step (
         .clock      (clock),
         .reset      (reset),
         .en         (en),
         .prev_stage (step_bus[j]),
         .next_stage (step_bus[j+1])
      );
   end

   // round to nearest, ties away from zero: (q2 + 1) / 2
   always_comb begin
      res_in.valid = step_bus[QUO_W-1].valid;
      for (int i = 0; i < ENTRIES; i++) begin
         tail_lane[i]   = step_bus[QUO_W-1].lane[i];
         rnd[i]         = {1'b0, tail_lane[i].quo} + (QUO_W+1)'(1);
         rounded[i]     = rnd[i][QUO_W:1];
         clip[i]        = tail_lane[i].ovf || (rounded[i] > {1'b0, ONE_MAG});
         res_in.neg[i]  = tail_lane[i].neg;
         res_in.sat[i]  = clip[i];
         res_in.mag[i]  = clip[i] ? ONE_MAG : rounded[i][MAGQ_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff.valid <= 1'b0;
      end else if (en) begin
         res_ff <= res_in;
      end
   end

   assign div_out = res_ff;

endmodule
